>>> rtl/ifp_pkg.sv
// Shared types, character codes and lookup functions for the infix-to-postfix converter.
`default_nettype none

package ifp_pkg;

  // Operator stack entry codes
  localparam logic [2:0] CODE_LPAREN = 3'd0;
  localparam logic [2:0] CODE_ADD    = 3'd1;
  localparam logic [2:0] CODE_SUB    = 3'd2;
  localparam logic [2:0] CODE_MUL    = 3'd3;
  localparam logic [2:0] CODE_DIV    = 3'd4;
  localparam logic [2:0] CODE_POW    = 3'd5;
  localparam logic [2:0] CODE_NONE   = 3'd7;

  localparam int unsigned CODE_W = 3;

  // ASCII characters
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EVAL,
    S_PUSH,
    S_FIN
  } state_e;

  typedef enum logic [1:0] {
    K_CHAR,
    K_RPAR,
    K_OP,
    K_END
  } kind_e;

  // One result beat handed from the sequencer to the output register
  typedef struct packed {
    logic       vld;
    logic [7:0] sym;
    logic       last;
    logic       expr_end;
    logic       ovf;
  } emit_t;

  function automatic logic [7:0] code_char(input logic [2:0] code);
    logic [7:0] c;
    case (code)
      CODE_ADD: c = CH_PLUS;
      CODE_SUB: c = CH_MINUS;
      CODE_MUL: c = CH_STAR;
      CODE_DIV: c = CH_SLASH;
      CODE_POW: c = CH_CARET;
      default:  c = CH_LPAREN;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] code_prec(input logic [2:0] code);
    logic [1:0] p;
    case (code)
      CODE_ADD, CODE_SUB: p = 2'd1;
      CODE_MUL, CODE_DIV: p = 2'd2;
      CODE_POW:           p = 2'd3;
      default:            p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic [2:0] op_code(input logic [7:0] ch);
    logic [2:0] c;
    case (ch)
      CH_PLUS:  c = CODE_ADD;
      CH_MINUS: c = CODE_SUB;
      CH_STAR:  c = CODE_MUL;
      CH_SLASH: c = CODE_DIV;
      CH_CARET: c = CODE_POW;
      default:  c = CODE_NONE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/ifp_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module ifp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/ifp_ctrl.sv
// Sequencer: decodes input characters and walks the operator stack one entry at a time.
`default_nettype none

module ifp_ctrl #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire                              func_i,
  input  wire  [7:0]                       symbol_i,
  input  wire                              out_free_i,
  output ifp_pkg::emit_t                   emit_o,
  output logic                             ram_we_o,
  output logic [$clog2(STACK_DEPTH)-1:0]   ram_waddr_o,
  output logic [ifp_pkg::CODE_W-1:0]       ram_wdata_o,
  output logic [$clog2(STACK_DEPTH)-1:0]   ram_raddr_o,
  input  wire  [ifp_pkg::CODE_W-1:0]       ram_rdata_i
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  ifp_pkg::state_e state_q, state_d;
  ifp_pkg::kind_e  kind_q, kind_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [2:0]      op_q, op_d;
  logic [1:0]      prec_q, prec_d;
  logic            ovf_q, ovf_d;
  logic            pend_vld_q, pend_vld_d;
  logic [7:0]      pend_sym_q, pend_sym_d;

  logic            acc;
  logic            is_digit, is_lpar, is_rpar, is_op;
  logic [2:0]      opc;
  logic            stack_empty, last_pop;
  logic [CW-1:0]   cnt_m1;
  logic            top_lpar, stop_pop, pop_emit, eval_stall, fin_busy;

  // Decode of the incoming character
  assign acc      = in_valid_i && (state_q == ifp_pkg::S_IDLE);
  assign is_digit = (symbol_i >= ifp_pkg::CH_ZERO) && (symbol_i <= ifp_pkg::CH_NINE);
  assign is_lpar  = (symbol_i == ifp_pkg::CH_LPAREN);
  assign is_rpar  = (symbol_i == ifp_pkg::CH_RPAREN);
  assign opc      = ifp_pkg::op_code(symbol_i);
  assign is_op    = (opc != ifp_pkg::CODE_NONE);

  assign stack_empty = (cnt_q == '0);
  assign last_pop    = (cnt_q == CW'(1));
  assign cnt_m1      = cnt_q - CW'(1);

  // Stack top compare against the pending item
  assign top_lpar = (ram_rdata_i == ifp_pkg::CODE_LPAREN);
  always_comb begin
    case (kind_q)
      ifp_pkg::K_RPAR: stop_pop = top_lpar;
      ifp_pkg::K_OP:   stop_pop = top_lpar || (ifp_pkg::code_prec(ram_rdata_i) < prec_q);
      default:         stop_pop = 1'b0;
    endcase
  end
  assign pop_emit   = !stop_pop && !((kind_q == ifp_pkg::K_END) && top_lpar);
  assign eval_stall = pop_emit && pend_vld_q && !out_free_i;
  assign fin_busy   = (pend_vld_q || (kind_q == ifp_pkg::K_END) || ovf_q) && !out_free_i;

  assign in_ready_o  = (state_q == ifp_pkg::S_IDLE);
  assign ram_raddr_o = cnt_m1[AW-1:0];
  assign ram_waddr_o = cnt_q[AW-1:0];
  assign ram_wdata_o = op_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ifp_pkg::S_IDLE: begin
        if (acc) begin
          if (func_i) begin
            state_d = stack_empty ? ifp_pkg::S_FIN : ifp_pkg::S_RD;
          end else if (is_digit) begin
            state_d = ifp_pkg::S_FIN;
          end else if (is_lpar) begin
            state_d = ifp_pkg::S_PUSH;
          end else if (is_rpar) begin
            state_d = stack_empty ? ifp_pkg::S_FIN : ifp_pkg::S_RD;
          end else if (is_op) begin
            state_d = stack_empty ? ifp_pkg::S_PUSH : ifp_pkg::S_RD;
          end
        end
      end
      ifp_pkg::S_RD: state_d = ifp_pkg::S_EVAL;
      ifp_pkg::S_EVAL: begin
        if (stop_pop) begin
          state_d = (kind_q == ifp_pkg::K_OP) ? ifp_pkg::S_PUSH : ifp_pkg::S_FIN;
        end else if (!eval_stall) begin
          if (last_pop) begin
            state_d = (kind_q == ifp_pkg::K_OP) ? ifp_pkg::S_PUSH : ifp_pkg::S_FIN;
          end else begin
            state_d = ifp_pkg::S_RD;
          end
        end
      end
      ifp_pkg::S_PUSH: state_d = ifp_pkg::S_FIN;
      ifp_pkg::S_FIN: begin
        if (!fin_busy) begin
          state_d = (pend_vld_q && (kind_q == ifp_pkg::K_END)) ? ifp_pkg::S_FIN
                                                                : ifp_pkg::S_IDLE;
        end
      end
      default: state_d = ifp_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    kind_d     = kind_q;
    cnt_d      = cnt_q;
    op_d       = op_q;
    prec_d     = prec_q;
    ovf_d      = ovf_q;
    pend_vld_d = pend_vld_q;
    pend_sym_d = pend_sym_q;
    ram_we_o   = 1'b0;
    emit_o     = '0;
    case (state_q)
      ifp_pkg::S_IDLE: begin
        if (acc) begin
          ovf_d  = 1'b0;
          op_d   = is_lpar ? ifp_pkg::CODE_LPAREN : opc;
          prec_d = ifp_pkg::code_prec(opc);
          if (func_i) begin
            kind_d = ifp_pkg::K_END;
          end else if (is_rpar) begin
            kind_d = ifp_pkg::K_RPAR;
          end else if (is_op) begin
            kind_d = ifp_pkg::K_OP;
          end else begin
            kind_d = ifp_pkg::K_CHAR;
          end
          if (!func_i && is_digit) begin
            pend_vld_d = 1'b1;
            pend_sym_d = symbol_i;
          end
        end
      end
      ifp_pkg::S_EVAL: begin
        if (stop_pop) begin
          // drop the matching '(' on close paren
          if (kind_q == ifp_pkg::K_RPAR) begin
            cnt_d = cnt_m1;
          end
        end else if (!pop_emit) begin
          cnt_d = cnt_m1;
        end else if (!eval_stall) begin
          cnt_d = cnt_m1;
          if (pend_vld_q) begin
            emit_o.vld = 1'b1;
            emit_o.sym = pend_sym_q;
          end
          pend_vld_d = 1'b1;
          pend_sym_d = ifp_pkg::code_char(ram_rdata_i);
        end
      end
      ifp_pkg::S_PUSH: begin
        if (cnt_q < CW'(STACK_DEPTH)) begin
          ram_we_o = 1'b1;
          cnt_d    = cnt_q + CW'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end
      ifp_pkg::S_FIN: begin
        if (out_free_i) begin
          if (pend_vld_q) begin
            emit_o.vld  = 1'b1;
            emit_o.sym  = pend_sym_q;
            emit_o.last = (kind_q != ifp_pkg::K_END);
            emit_o.ovf  = ovf_q && (kind_q != ifp_pkg::K_END);
            pend_vld_d  = 1'b0;
          end else if (kind_q == ifp_pkg::K_END) begin
            emit_o.vld      = 1'b1;
            emit_o.sym      = ifp_pkg::CH_NUL;
            emit_o.last     = 1'b1;
            emit_o.expr_end = 1'b1;
          end else if (ovf_q) begin
            emit_o.vld  = 1'b1;
            emit_o.sym  = ifp_pkg::CH_NUL;
            emit_o.last = 1'b1;
            emit_o.ovf  = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ifp_pkg::S_IDLE;
      cnt_q      <= '0;
      pend_vld_q <= 1'b0;
      ovf_q      <= 1'b0;
      kind_q     <= ifp_pkg::K_CHAR;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      pend_vld_q <= pend_vld_d;
      ovf_q      <= ovf_d;
      kind_q     <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    prec_q     <= prec_d;
    pend_sym_q <= pend_sym_d;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH))
    else $error("stack count above depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("push did not advance the stack count");

  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ifp_pkg::S_IDLE) |-> !pend_vld_q)
    else $error("pending result left over at item boundary");
`endif

endmodule

`default_nettype wire

>>> rtl/infix_to_postfix_converter_core.sv
// Top level of the shunting-yard infix-to-postfix converter with stream ports.
// Flow: a digit is held as the pending result and goes to the output register in S_FIN
//   once it is free; an operator, ')' or end beat visits S_RD and S_EVAL per stack entry
//   examined, then S_PUSH (operators) and S_FIN. A new input beat is taken only in S_IDLE,
//   after the previous one is done; the single stack RAM read port visits one entry at a time.
// Reset: rst_ni is asynchronous, active low; it empties the stack and the output register.
`default_nettype none

module infix_to_postfix_converter_core #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] symbol
  input  wire         s_axis_tuser,   // [0] func (1 = end of expression)
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_symbol
  output logic        m_axis_tlast,   // last_of_run
  output logic [1:0]  m_axis_tuser    // [0] expr_end, [1] overflow
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);

  ifp_pkg::emit_t                 emit;
  logic                           out_free;
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [AW-1:0]                  ram_raddr;
  logic [ifp_pkg::CODE_W-1:0]     ram_wdata;
  logic [ifp_pkg::CODE_W-1:0]     ram_rdata;

  logic       out_vld_q, out_vld_d;
  logic [7:0] out_sym_q;
  logic       out_last_q, out_end_q, out_ovf_q;

  // Output register can take a new beat when empty or draining this cycle
  assign out_free = !out_vld_q || m_axis_tready;

  // Sequencer: decode, stack walk and result ordering
  ifp_ctrl #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .func_i     (s_axis_tuser),
    .symbol_i   (s_axis_tdata),
    .out_free_i (out_free),
    .emit_o     (emit),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata)
  );

  // Operator stack storage; entries are read only after being pushed
  ifp_ram #(
    .WIDTH(ifp_pkg::CODE_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Hold the beat until taken; load a new one whenever the sequencer emits
  always_comb begin
    out_vld_d = out_vld_q;
    if (emit.vld) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.vld) begin
      out_sym_q  <= emit.sym;
      out_last_q <= emit.last;
      out_end_q  <= emit.expr_end;
      out_ovf_q  <= emit.ovf;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_sym_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = {out_ovf_q, out_end_q};

`ifndef SYNTHESIS
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.vld |-> out_free)
    else $error("result emitted while output register is full");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_end_q) |-> out_last_q)
    else $error("end marker not flagged as last");

  a_ovf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_ovf_q) |-> (out_last_q && !out_end_q))
    else $error("overflow flag on a non-final beat");
`endif

endmodule

`default_nettype wire
